// ===== design/wpai_pkg.sv =====
// ----------------------------------------------------------------------------
// wpai_pkg
// Shared types, constants and threshold table of the windowed pollutant
// average index block.
// ----------------------------------------------------------------------------
package wpai_pkg;

  // field widths
  localparam int VAL_W   = 20;
  localparam int TIME_W  = 32;
  localparam int POLL_W  = 2;
  localparam int LVL_W   = 3;

  // largest pollutant and threshold counts the table covers
  localparam int MAX_POLL = 8;
  localparam int MAX_THR  = 8;
  localparam int LANE_W   = 3;

  // averages carried in a result word
  localparam int OUT_AVGS = 4;

  // restoring divider: one quotient bit per step
  localparam int DIV_STEPS = VAL_W;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  // stream word layouts
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_BITS    = OUT_AVGS * VAL_W + LVL_W;
  localparam int OUT_TDATA_W = 88;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 1'b1;

  // unused threshold slot, never strictly exceeded
  localparam logic [VAL_W-1:0] NO_THR = 20'hFFFFF;

  // thresholds in Q16.4 (integer threshold times 16)
  localparam logic [VAL_W-1:0] LEVEL_TABLE [MAX_POLL][MAX_THR] = '{
    '{20'd320,  20'd640,  20'd800,  20'd1600, 20'd2400,  NO_THR, NO_THR, NO_THR},
    '{20'd640,  20'd1440, 20'd1920, 20'd3680, 20'd5440,  NO_THR, NO_THR, NO_THR},
    '{20'd800,  20'd1600, 20'd2080, 20'd3840, 20'd6080,  NO_THR, NO_THR, NO_THR},
    '{20'd1600, 20'd3200, 20'd5600, 20'd8000, 20'd12000, NO_THR, NO_THR, NO_THR},
    '{NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR},
    '{NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR},
    '{NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR},
    '{NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR, NO_THR}
  };

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REPORT = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_PUBLISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              accum;
    logic              best_init;
    logic              div_load;
    logic              div_step;
    logic              div_store;
    logic              publish;
    logic [LANE_W-1:0] lane;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== design/windowed_pollutant_average_index_top.sv =====
// Add word: accepted, then window check and accumulate.
// Report word: accepted, then each pollutant in turn is divided by the
//   shared restoring divider, one quotient bit per cycle, 20 bits per pollutant.
// One word is in work at a time; the result waits in an output register
//   while the next word is taken.
// Reset: window spans all timestamps, sums and counts zero, no result pending.
// ----------------------------------------------------------------------------
// windowed_pollutant_average_index_top
// Windowed per-pollutant averaging with an air quality index on report.
// ----------------------------------------------------------------------------
module windowed_pollutant_average_index_top
  import wpai_pkg::*;
#(
  parameter int NUM_POLLUTANTS = 4,
  parameter int NUM_THRESHOLDS = 5,
  parameter int COUNT_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIME_W-1:0]      cfg_data,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pollutant [1:0], sample_time [33:2], sample_value [53:34], zero [55:54]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode [0]
  input  logic [0:0]             s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // avg_pm10 [19:0], avg_no2 [39:20], avg_o3 [59:40], avg_so2 [79:60],
  // quality_index [82:80], zero [87:83]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  wpai_ctrl #(
    .NUM_POLLUTANTS(NUM_POLLUTANTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_opcode(opcode_t'(s_axis_tuser[0])),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wpai_datapath #(
    .NUM_POLLUTANTS(NUM_POLLUTANTS),
    .NUM_THRESHOLDS(NUM_THRESHOLDS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule

// ===== design/wpai_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpai_ctrl
// Sequencer: takes input words, runs the accumulate step or the per-pollutant
// divide sequence of a report, and hands the result to the output register.
// ----------------------------------------------------------------------------
module wpai_ctrl
  import wpai_pkg::*;
#(
  parameter int NUM_POLLUTANTS = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  opcode_t in_opcode,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(NUM_POLLUTANTS - 1);

  state_t            state, state_next;
  logic [LANE_W-1:0] lane, lane_next;
  logic [STEP_W-1:0] step, step_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lane  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
      step  <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    lane_next  = lane;
    step_next  = step;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.lane   = lane;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_opcode == OP_REPORT) begin
            cmd.best_init = 1'b1;
            state_next    = ST_DIV_LOAD;
          end else begin
            state_next = ST_ACCUM;
          end
        end
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (step == STEP_LAST) begin
          step_next  = '0;
          state_next = ST_DIV_STORE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (lane == LANE_LAST) begin
          lane_next  = '0;
          state_next = ST_PUBLISH;
        end else begin
          lane_next  = lane + 1'b1;
          state_next = ST_DIV_LOAD;
        end
      end
      ST_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // step counter only runs while dividing
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_DIV_STEP |-> step == '0)
    else $error("divide step counter nonzero outside divide");

  // a report starts its divide sequence at the first pollutant
  a_report_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_opcode == OP_REPORT |=> state == ST_DIV_LOAD && lane == '0)
    else $error("report did not start at first pollutant");

endmodule

// ===== design/wpai_datapath.sv =====
// ----------------------------------------------------------------------------
// wpai_datapath
// Window registers, per-pollutant sums and counts, shared restoring divider,
// level lookup and the output register.
// ----------------------------------------------------------------------------
module wpai_datapath
  import wpai_pkg::*;
#(
  parameter int NUM_POLLUTANTS = 4,
  parameter int NUM_THRESHOLDS = 5,
  parameter int COUNT_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIME_W-1:0]      cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int SUM_W = VAL_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [TIME_W-1:0]     window_start;
  logic [TIME_W-1:0]     window_end;
  logic [POLL_W-1:0]     item_poll;
  logic [TIME_W-1:0]     item_time;
  logic [VAL_W-1:0]      item_value;
  logic [SUM_W-1:0]      sums [NUM_POLLUTANTS];
  logic [COUNT_BITS-1:0] counts [NUM_POLLUTANTS];
  logic [COUNT_BITS-1:0] rem;
  logic [VAL_W-1:0]      quo;
  logic [LVL_W-1:0]      best;
  logic [VAL_W-1:0]      avgs [OUT_AVGS];

  logic                  in_window;
  logic [SUM_W-1:0]      sel_sum;
  logic [COUNT_BITS-1:0] sel_count;
  logic [COUNT_BITS:0]   shifted;
  logic                  sub_ok;
  logic [COUNT_BITS:0]   diff;
  logic [VAL_W-1:0]      avg;
  logic [LVL_W-1:0]      level;
  logic                  run;
  logic                  any_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_START: window_start <= cfg_data;
        CFG_WINDOW_END:   window_end   <= cfg_data;
        default:          window_end   <= window_end;
      endcase
    end
  end

  // captured input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_poll  <= in_data[POLL_W-1:0];
      item_time  <= in_data[POLL_W +: TIME_W];
      item_value <= in_data[POLL_W + TIME_W +: VAL_W];
    end
  end

  assign in_window = (item_time >= window_start) && (item_time <= window_end);

  // per-pollutant sums and saturating counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POLLUTANTS; i++) begin
        sums[i]   <= '0;
        counts[i] <= '0;
      end
    end else if (cmd.publish) begin
      for (int i = 0; i < NUM_POLLUTANTS; i++) begin
        sums[i]   <= '0;
        counts[i] <= '0;
      end
    end else if (cmd.accum && in_window) begin
      for (int i = 0; i < NUM_POLLUTANTS; i++) begin
        if (int'(item_poll) == i && counts[i] != COUNT_MAX) begin
          sums[i]   <= sums[i] + SUM_W'(item_value);
          counts[i] <= counts[i] + 1'b1;
        end
      end
    end
  end

  // pollutant selected for the divider
  always_comb begin
    sel_sum   = '0;
    sel_count = '0;
    any_count = 1'b0;
    for (int i = 0; i < NUM_POLLUTANTS; i++) begin
      if (int'(cmd.lane) == i) begin
        sel_sum   = sums[i];
        sel_count = counts[i];
      end
      any_count = any_count | (counts[i] != '0);
    end
  end

  // one restoring divide step
  assign shifted = {rem, quo[VAL_W-1]};
  assign sub_ok  = shifted >= {1'b0, sel_count};
  assign diff    = shifted - {1'b0, sel_count};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= sel_sum[SUM_W-1:VAL_W];
      quo <= sel_sum[VAL_W-1:0];
    end else if (cmd.div_step) begin
      rem <= sub_ok ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      quo <= {quo[VAL_W-2:0], sub_ok};
    end
  end

  // average and its level from the table
  assign avg = (sel_count == '0) ? '0 : quo;

  always_comb begin
    run   = 1'b1;
    level = LVL_W'(1);
    for (int t = 0; t < MAX_THR; t++) begin
      if (t < NUM_THRESHOLDS) begin
        run   = run & (avg > LEVEL_TABLE[cmd.lane][t]);
        level = level + LVL_W'(run);
      end
    end
  end

  // staged averages and running maximum level
  always_ff @(posedge clk) begin
    if (cmd.best_init) begin
      best <= LVL_W'(1);
      for (int i = 0; i < OUT_AVGS; i++) begin
        avgs[i] <= '0;
      end
    end else if (cmd.div_store) begin
      for (int i = 0; i < OUT_AVGS; i++) begin
        if (int'(cmd.lane) == i) begin
          avgs[i] <= avg;
        end
      end
      if (level > best) begin
        best <= level;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data <= {(OUT_TDATA_W - OUT_BITS)'(0), best, avgs[3], avgs[2], avgs[1], avgs[0]};
    end
  end

  assign status.out_free = !out_valid || out_ready;

  // a published result shows up at the output
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published result not valid");

  // a report leaves all counts cleared
  a_publish_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> !any_count)
    else $error("counts not cleared after report");

  // the index of a shown result stays within its range
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[OUT_AVGS*VAL_W +: LVL_W] >= LVL_W'(1)
              && out_data[OUT_AVGS*VAL_W +: LVL_W] <= LVL_W'(6))
    else $error("quality index out of range");

endmodule

// ===== dv/windowed_pollutant_average_index_top_test.sv =====
// ----------------------------------------------------------------------------
// windowed_pollutant_average_index_top_test
// Drives measurement and report words into the averaging block, predicts each
// report word from a model of the window sums and counts, and checks every
// result word field by field. Covers field extremes, index thresholds, window
// bounds, long accumulation runs and long random traffic under random idling.
// ----------------------------------------------------------------------------
module windowed_pollutant_average_index_top_test;
  import wpai_pkg::*;

  localparam int NUM_POLLUTANTS = 4;
  localparam int NUM_THRESHOLDS = 5;
  localparam int COUNT_BITS     = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
  localparam int QUIET_CYCLES   = 120;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_WORDS    = 200;
  localparam int LONG_RUN_WORDS = 200;

  typedef enum logic [POLL_W-1:0] {
    PM10 = 2'd0,
    NO2  = 2'd1,
    O3   = 2'd2,
    SO2  = 2'd3
  } pollutant_t;

  typedef struct packed {
    logic [OUT_AVGS-1:0][VAL_W-1:0] avg;
    logic [LVL_W-1:0]               index;
  } report_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [TIME_W-1:0]      cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // pollutant [1:0], sample_time [33:2], sample_value [53:34], zero [55:54]
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // opcode [0]
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // avg_pm10 [19:0], avg_no2 [39:20], avg_o3 [59:40], avg_so2 [79:60],
  // quality_index [82:80], zero [87:83]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // model of the block's window and accumulators
  logic [TIME_W-1:0]     win_start;
  logic [TIME_W-1:0]     win_end;
  logic [35:0]           acc_sum   [NUM_POLLUTANTS];
  logic [COUNT_BITS-1:0] acc_count [NUM_POLLUTANTS];

  report_t pending_reports [$];
  int      error_count = 0;
  int      cycle_count = 0;
  logic    steady;
  string   avg_field_name [OUT_AVGS] = '{"avg_pm10", "avg_no2", "avg_o3", "avg_so2"};

  windowed_pollutant_average_index_top #(
    .NUM_POLLUTANTS (NUM_POLLUTANTS),
    .NUM_THRESHOLDS (NUM_THRESHOLDS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 14);
  end

  // update the model for one accepted word, queue the report it causes
  task automatic account_word(input opcode_t op, input logic [POLL_W-1:0] p,
                              input logic [TIME_W-1:0] t, input logic [VAL_W-1:0] v);
    report_t          r;
    logic [LVL_W-1:0] lvl;
    logic             stop;
    if (op == OP_ADD) begin
      if (p < NUM_POLLUTANTS && t >= win_start && t <= win_end
          && acc_count[p] != COUNT_FULL) begin
        acc_sum[p]   = acc_sum[p] + v;
        acc_count[p] = acc_count[p] + 1'b1;
      end
    end else begin
      r = '0;
      r.index = LVL_W'(1);
      for (int i = 0; i < NUM_POLLUTANTS; i++) begin
        if (acc_count[i] != 0)
          r.avg[i] = VAL_W'(acc_sum[i] / acc_count[i]);
        // level is 1 plus the thresholds strictly exceeded in a row
        lvl  = LVL_W'(1);
        stop = 1'b0;
        for (int k = 0; k < NUM_THRESHOLDS; k++) begin
          if (!stop && r.avg[i] > LEVEL_TABLE[i][k])
            lvl = lvl + 1'b1;
          else
            stop = 1'b1;
        end
        if (lvl > r.index)
          r.index = lvl;
        acc_sum[i]   = '0;
        acc_count[i] = '0;
      end
      pending_reports = {pending_reports, r};
    end
  endtask

  // send one word, with a random gap in front of it
  task automatic send_word(input opcode_t op, input logic [POLL_W-1:0] p,
                           input logic [TIME_W-1:0] t, input logic [VAL_W-1:0] v);
    if (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 14);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, v, t, p};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    account_word(op, p, t, v);
  endtask

  task automatic add(input pollutant_t p, input logic [TIME_W-1:0] t,
                     input logic [VAL_W-1:0] v);
    send_word(OP_ADD, p, t, v);
  endtask

  task automatic report();
    send_word(OP_REPORT, POLL_W'($urandom), $urandom, VAL_W'($urandom));
  endtask

  // hold off until every queued report has come out
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic wait_quiet();
    drain_reports();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WINDOW_START)
      win_start = d;
    else
      win_end = d;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [TIME_W-1:0] ws, input logic [TIME_W-1:0] we);
    wait_quiet();
    write_reg(CFG_WINDOW_START, ws);
    write_reg(CFG_WINDOW_END, we);
  endtask

  // timestamp near or inside the current window, or fully random
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(7))
      0: return win_start - 1'b1;
      1: return win_end + 1'b1;
      2: return win_start;
      3: return win_end;
      4: return $urandom;
      default: begin
        if (win_start <= win_end)
          return win_start + $urandom_range(win_end - win_start);
        return $urandom;
      end
    endcase
  endfunction

  // concentration: full range, small, up to 20000, or close to a threshold
  function automatic logic [VAL_W-1:0] pick_value(input logic [POLL_W-1:0] p);
    case ($urandom_range(3))
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(4095));
      2: return VAL_W'(LEVEL_TABLE[p][$urandom_range(NUM_THRESHOLDS - 1)]
                       + $urandom_range(2) - 1);
      default: return VAL_W'($urandom_range(20000));
    endcase
  endfunction

  // report straight after reset, nothing accumulated
  task automatic test_empty_report();
    report();
  endtask

  // timestamp and value extremes, truncating average, ignored report fields
  task automatic test_field_extremes();
    add(PM10, 32'h0000_0000, 20'hFFFFF);
    add(NO2, 32'hFFFF_FFFF, 20'h00000);
    add(O3, $urandom, 20'hFFFFF);
    add(O3, $urandom, 20'h00000);
    add(SO2, $urandom, 20'd1);
    add(SO2, $urandom, 20'd2);
    send_word(OP_REPORT, SO2, 32'hFFFF_FFFF, 20'hFFFFF);
  endtask

  // averages exactly on and just above thresholds
  task automatic test_level_thresholds();
    add(SO2, $urandom, 20'd12000);
    report();
    add(SO2, $urandom, 20'd12001);
    report();
    add(PM10, $urandom, 20'd320);
    add(NO2, $urandom, 20'd641);
    add(O3, $urandom, 20'd2081);
    report();
  endtask

  // inclusive bounds, empty window, single-timestamp window at the top
  task automatic test_window_bounds();
    set_window(32'd100, 32'd200);
    add(PM10, 32'd99, 20'd5000);
    add(PM10, 32'd100, 20'd700);
    add(NO2, 32'd200, 20'd900);
    add(NO2, 32'd201, 20'd9000);
    report();
    set_window(32'hFFFF_FFFF, 32'h0000_0000);
    add(O3, 32'h0000_0000, 20'd1000);
    add(O3, 32'hFFFF_FFFF, 20'd1000);
    report();
    set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add(SO2, 32'hFFFF_FFFE, 20'd4000);
    add(SO2, 32'hFFFF_FFFF, 20'd2000);
    report();
    set_window(32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // many words to one pollutant, then a second report on cleared state
  task automatic test_long_run();
    add(NO2, $urandom, VAL_W'($urandom));
    for (int i = 0; i < LONG_RUN_WORDS; i++)
      add(O3, $urandom, VAL_W'($urandom_range(4000)));
    repeat (4) add(O3, $urandom, 20'hFFFFF);
    report();
    report();
  endtask

  // random traffic over several window settings
  task automatic test_random_traffic();
    logic [TIME_W-1:0] ws;
    logic [TIME_W-1:0] span;
    logic [POLL_W-1:0] p;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_window(32'h0000_0000, 32'hFFFF_FFFF);
        1: begin
          ws   = $urandom;
          span = $urandom_range(100000);
          set_window(ws, (ws > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : ws + span);
        end
        2: set_window(32'h0000_0000, $urandom_range(1000));
        3: set_window($urandom, 32'hFFFF_FFFF);
        4: begin
          ws = $urandom_range(32'hFFFF_FFFF, 1);
          set_window(ws, ws - 1'b1);
        end
        default: set_window($urandom, $urandom);
      endcase
      // first phase runs with no idling on either side
      steady = (ph == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 2 && n == PHASE_WORDS / 2)
          drain_reports();
        if ($urandom_range(9) == 0) begin
          report();
        end else begin
          p = POLL_W'($urandom);
          send_word(OP_ADD, p, pick_time(), pick_value(p));
        end
      end
      report();
    end
    steady = 1'b0;
  endtask

  // check each result word against the oldest queued report
  always @(posedge clk) begin
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result word with no report pending: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        for (int i = 0; i < OUT_AVGS; i++) begin
          if (m_axis_tdata[i*VAL_W +: VAL_W] !== want.avg[i]) begin
            $error("%s: expected %0d, got %0d", avg_field_name[i], want.avg[i],
                   m_axis_tdata[i*VAL_W +: VAL_W]);
            error_count++;
          end
        end
        if (m_axis_tdata[OUT_AVGS*VAL_W +: LVL_W] !== want.index) begin
          $error("quality_index: expected %0d, got %0d", want.index,
                 m_axis_tdata[OUT_AVGS*VAL_W +: LVL_W]);
          error_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    steady        = 1'b0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_WINDOW_START;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ADD;
    win_start     = '0;
    win_end       = '1;
    for (int i = 0; i < NUM_POLLUTANTS; i++) begin
      acc_sum[i]   = '0;
      acc_count[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_report();
    test_field_extremes();
    test_level_thresholds();
    test_window_bounds();
    test_long_run();
    test_random_traffic();

    wait_quiet();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
design/wpai_pkg.sv
design/wpai_ctrl.sv
design/wpai_datapath.sv
design/windowed_pollutant_average_index_top.sv
dv/windowed_pollutant_average_index_top_test.sv
